FILE: hdl/cmx_pkg.sv
package cmx_pkg;

    localparam int MAX_DIM_DEF      = 8;
    localparam int MAX_VECTORS_DEF  = 1024;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [39:0] cov_value;
        logic signed [23:0] row_mean;
        logic [1:0]         status;
        logic               end_of_matrix;
    } t_out_word;

endpackage

FILE: hdl/covariance_matrix.sv
// Population covariance matrix over a set of vectors.
// Input channel: i_in_valid / o_in_stall carry one word per vector component
// (sample, last). A word is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry one word per matrix entry,
// row-major, end_of_matrix on the final entry.
// Config channel: i_cfg_valid / o_cfg_ready writes dim (always ready).
// A component that does not close a vector is only buffered. One that closes
// a vector (below MAX_VECTORS) updates the component sums per row and the cross
// sums one product at a time through the single shared multiplier and the
// cross-sum RAM read-modify-write.
// On last, each of the d*d entries is computed by the bit-serial divider run
// twice per entry (covariance, then row mean); the divider is skipped when no
// vector completed.
// o_in_stall is high once a word that starts work is taken, until the work is done.
// When the receiver stalls, the entry word holds and the sequencer waits.
// After the last entry is taken all sums are cleared; dim is kept.
// Reset (synchronous, active low) clears all sums and sets dim to 8.
module covariance_matrix #(
    parameter int MAX_DIM      = cmx_pkg::MAX_DIM_DEF,
    parameter int MAX_VECTORS  = cmx_pkg::MAX_VECTORS_DEF,
    parameter int SAMPLE_WIDTH = cmx_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cmx_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cmx_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_data
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = 1 << (2 * IW);
    localparam int CNT_W = $clog2(MAX_VECTORS + 1);
    localparam int SW    = SAMPLE_WIDTH;
    localparam int SUM_W = SW + CNT_W;
    localparam int XW    = 2 * SW + CNT_W;
    localparam int MW    = SUM_W + 1;
    localparam int NUM_W = 2 * MW;
    localparam int DEN_W = 2 * CNT_W;
    localparam int DV_W  = NUM_W + 8;
    localparam int DC_W  = $clog2(DV_W);
    localparam int QX    = (DV_W > 40) ? DV_W : 40;
    localparam int CW    = 5;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_ACC_I    = 4'd1;
    localparam logic [3:0] S_ACC_J    = 4'd2;
    localparam logic [3:0] S_ACC_W    = 4'd3;
    localparam logic [3:0] S_E_A      = 4'd4;
    localparam logic [3:0] S_E_B      = 4'd5;
    localparam logic [3:0] S_E_C      = 4'd6;
    localparam logic [3:0] S_E_D      = 4'd7;
    localparam logic [3:0] S_E_E      = 4'd8;
    localparam logic [3:0] S_E_F      = 4'd9;
    localparam logic [3:0] S_DIV_COV  = 4'd10;
    localparam logic [3:0] S_DIV_MEAN = 4'd11;
    localparam logic [3:0] S_OUT      = 4'd12;

    logic [3:0]               r_state;
    logic [3:0]               r_dim;
    logic [3:0]               eff_d;
    logic signed [SW-1:0]     r_buf [MAX_DIM];
    logic signed [SUM_W-1:0]  r_csum [MAX_DIM];
    logic [IW-1:0]            r_cidx;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ovf;
    logic                     r_last;
    logic [IW-1:0]            r_i;
    logic [IW-1:0]            r_j;
    logic signed [SW-1:0]     r_bi;
    logic signed [SUM_W-1:0]  r_sx;
    logic [XW-1:0]            r_xy;
    logic [DEN_W-1:0]         r_nn;
    logic signed [NUM_W-1:0]  r_prod;
    logic signed [NUM_W-1:0]  r_acc;
    logic [DV_W-1:0]          r_dvd;
    logic [DEN_W-1:0]         r_rem;
    logic [DEN_W-1:0]         r_den;
    logic [DC_W-1:0]          r_dcnt;
    logic                     r_neg;
    logic [39:0]              r_cov;
    logic [23:0]              r_mean;
    logic [XW-1:0]            r_xmem [DEPTH];
    logic                     r_xval [DEPTH];
    logic [XW-1:0]            r_rdata;
    logic                     r_rval;

    logic signed [SW-1:0]     s_in;
    logic signed [SW-1:0]     buf_rd;
    logic signed [SUM_W-1:0]  csum_rd;
    logic [IW-1:0]            buf_idx;
    logic [IW-1:0]            csum_idx;
    logic signed [MW-1:0]     m_a;
    logic signed [MW-1:0]     m_b;
    logic signed [NUM_W-1:0]  m_p;
    logic [MW-1:0]            n_ext;
    logic [2*IW-1:0]          addr;
    logic                     xwe;
    logic [XW-1:0]            xwdata;
    logic                     clr;
    logic                     vec_done;
    logic                     last_i;
    logic                     last_j;
    logic [DEN_W:0]           rem_sh;
    logic                     ge;
    logic [DEN_W:0]           rem_sub;
    logic [DV_W-1:0]          q_next;
    logic [QX-1:0]            qx;
    logic [QX-1:0]            qx_s;
    logic [NUM_W-1:0]         acc_mag;
    logic [SUM_W-1:0]         sx_mag;
    logic [1:0]               status;
    logic                     in_acc;
    logic                     out_acc;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;

    always_comb begin
        if (r_dim == 4'd0) begin
            eff_d = 4'd1;
        end else if (r_dim > 4'(MAX_DIM)) begin
            eff_d = 4'(MAX_DIM);
        end else begin
            eff_d = r_dim;
        end
    end

    assign s_in     = i_in_word.sample[SW-1:0];
    assign vec_done = (CW'(r_cidx) + CW'(1)) >= CW'(eff_d);
    assign last_i   = (CW'(r_i) + CW'(1)) >= CW'(eff_d);
    assign last_j   = (CW'(r_j) + CW'(1)) >= CW'(eff_d);
    assign buf_idx  = (r_state == S_ACC_J) ? r_j : r_i;
    assign csum_idx = (r_state == S_E_B) ? r_j : r_i;
    assign buf_rd   = r_buf[buf_idx];
    assign csum_rd  = r_csum[csum_idx];
    assign n_ext    = MW'(r_cnt);
    assign addr     = {r_i, r_j};
    assign status   = (r_cnt == '0) ? cmx_pkg::ST_EMPTY
                    : (r_ovf ? cmx_pkg::ST_DROPPED : cmx_pkg::ST_OK);

    // shared multiplier
    always_comb begin
        unique case (r_state)
            S_ACC_J: begin
                m_a = MW'(r_bi);
                m_b = MW'(buf_rd);
            end
            S_E_A: begin
                m_a = n_ext;
                m_b = n_ext;
            end
            S_E_B: begin
                m_a = MW'(r_sx);
                m_b = MW'(csum_rd);
            end
            S_E_C: begin
                m_a = n_ext;
                m_b = {1'b0, r_xy[SUM_W-1:0]};
            end
            S_E_D: begin
                m_a = n_ext;
                m_b = MW'($signed(r_xy[XW-1:SUM_W]));
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end
    assign m_p = m_a * m_b;

    // bit-serial restoring divider step
    assign rem_sh  = {r_rem, r_dvd[DV_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_next  = {r_dvd[DV_W-2:0], ge};
    assign qx      = QX'(q_next);
    assign qx_s    = r_neg ? (~qx + QX'(1)) : qx;
    assign acc_mag = r_acc[NUM_W-1] ? NUM_W'(-r_acc) : NUM_W'(r_acc);
    assign sx_mag  = r_sx[SUM_W-1] ? SUM_W'(-r_sx) : SUM_W'(r_sx);

    assign xwe    = (r_state == S_ACC_W);
    assign xwdata = (r_rval ? r_rdata : '0) + r_prod[XW-1:0];
    assign clr    = out_acc && last_i && last_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dim   <= 4'd8;
            r_cidx  <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            for (int k = 0; k < MAX_DIM; k++) begin
                r_buf[k]  <= '0;
                r_csum[k] <= '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_dim <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_buf[r_cidx] <= s_in;
                        r_last        <= i_in_word.last;
                        r_i           <= '0;
                        r_j           <= '0;
                        if (vec_done) begin
                            r_cidx <= '0;
                            if (r_cnt < CNT_W'(MAX_VECTORS)) begin
                                r_cnt   <= r_cnt + CNT_W'(1);
                                r_state <= S_ACC_I;
                            end else begin
                                r_ovf <= 1'b1;
                                if (i_in_word.last) begin
                                    r_state <= S_E_A;
                                end
                            end
                        end else begin
                            r_cidx <= r_cidx + IW'(1);
                            if (i_in_word.last) begin
                                r_state <= S_E_A;
                            end
                        end
                    end
                end
                S_ACC_I: begin
                    r_bi          <= buf_rd;
                    r_csum[r_i]   <= r_csum[r_i] + SUM_W'(buf_rd);
                    r_state       <= S_ACC_J;
                end
                S_ACC_J: begin
                    r_state <= S_ACC_W;
                end
                S_ACC_W: begin
                    if (!last_j) begin
                        r_j     <= r_j + IW'(1);
                        r_state <= S_ACC_J;
                    end else if (!last_i) begin
                        r_j     <= '0;
                        r_i     <= r_i + IW'(1);
                        r_state <= S_ACC_I;
                    end else begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= r_last ? S_E_A : S_IDLE;
                    end
                end
                S_E_A: begin
                    r_state <= (r_cnt == '0) ? S_OUT : S_E_B;
                end
                S_E_B:      r_state <= S_E_C;
                S_E_C:      r_state <= S_E_D;
                S_E_D:      r_state <= S_E_E;
                S_E_E:      r_state <= S_E_F;
                S_E_F:      r_state <= S_DIV_COV;
                S_DIV_COV: begin
                    if (r_dcnt == '0) begin
                        r_state <= S_DIV_MEAN;
                    end
                end
                S_DIV_MEAN: begin
                    if (r_dcnt == '0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (!last_j) begin
                            r_j     <= r_j + IW'(1);
                            r_state <= S_E_A;
                        end else if (!last_i) begin
                            r_j     <= '0;
                            r_i     <= r_i + IW'(1);
                            r_state <= S_E_A;
                        end else begin
                            r_i     <= '0;
                            r_j     <= '0;
                            r_cidx  <= '0;
                            r_cnt   <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                            for (int k = 0; k < MAX_DIM; k++) begin
                                r_buf[k]  <= '0;
                                r_csum[k] <= '0;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
        unique case (r_state)
            S_E_A: begin
                r_sx  <= r_csum[r_i];
                r_cov <= '0;
                r_mean <= '0;
            end
            S_E_B: begin
                r_xy <= r_rval ? r_rdata : '0;
                r_nn <= r_prod[DEN_W-1:0];
            end
            S_E_C: r_acc <= -r_prod;
            S_E_D: r_acc <= r_acc + r_prod;
            S_E_E: r_acc <= r_acc + (r_prod <<< SUM_W);
            S_E_F: begin
                r_neg  <= r_acc[NUM_W-1];
                r_dvd  <= {acc_mag, 8'd0};
                r_den  <= r_nn;
                r_rem  <= '0;
                r_dcnt <= DC_W'(DV_W - 1);
            end
            S_DIV_COV, S_DIV_MEAN: begin
                if ((r_dcnt == '0) && (r_state == S_DIV_COV)) begin
                    r_cov  <= qx_s[39:0];
                    r_neg  <= r_sx[SUM_W-1];
                    r_dvd  <= {NUM_W'(sx_mag), 8'd0};
                    r_den  <= DEN_W'(r_cnt);
                    r_rem  <= '0;
                    r_dcnt <= DC_W'(DV_W - 1);
                end else begin
                    r_rem  <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                    r_dvd  <= q_next;
                    r_dcnt <= r_dcnt - DC_W'(1);
                    if (r_dcnt == '0) begin
                        r_mean <= qx_s[23:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // cross-sum RAM
    always_ff @(posedge i_clk) begin
        if (xwe) begin
            r_xmem[addr] <= xwdata;
        end
        r_rdata <= r_xmem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rval <= 1'b0;
            for (int k = 0; k < DEPTH; k++) begin
                r_xval[k] <= 1'b0;
            end
        end else begin
            r_rval <= r_xval[addr];
            if (clr) begin
                for (int k = 0; k < DEPTH; k++) begin
                    r_xval[k] <= 1'b0;
                end
            end else if (xwe) begin
                r_xval[addr] <= 1'b1;
            end
        end
    end

    assign o_out_word.row           = 3'(r_i);
    assign o_out_word.col           = 3'(r_j);
    assign o_out_word.cov_value     = r_cov;
    assign o_out_word.row_mean      = r_mean;
    assign o_out_word.status        = status;
    assign o_out_word.end_of_matrix = last_i && last_j;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CW'(r_i) < CW'(eff_d)) && (CW'(r_j) < CW'(eff_d)))
        else $error("entry index beyond dim");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_word.end_of_matrix) |=> (r_state == S_IDLE) && (r_cnt == '0)
        && !r_ovf && (r_cidx == '0))
        else $error("stores not cleared after matrix");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_cnt == '0)) |-> (r_cov == '0) && (r_mean == '0)
        && (o_out_word.status == cmx_pkg::ST_EMPTY))
        else $error("empty matrix entry not zero");

    a_cidx_below_dim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cidx == '0) || (CW'(r_cidx) < CW'(eff_d)))
        else $error("component index past dim");

endmodule
